### rtl/bmd_pkg.sv
// bmd_pkg: shared types, constants and register codes of the button majority debounce unit
// no dependencies
`timescale 1ns / 1ps

package bmd_pkg;

   localparam int FIELD_W      = 5;
   localparam int PERIOD_W     = 16;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   localparam int NUM_BUTTONS_DEFAULT = 5;
   localparam int WINDOW_DEFAULT      = 5;

   typedef logic [FIELD_W-1:0]    field_type;
   typedef logic [PERIOD_W-1:0]   period_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

   localparam period_type PERIOD_RESET = period_type'(10);
   localparam field_type  INVERT_RESET = field_type'(31);

   // register index, taken from paddr[2]
   localparam logic REG_SAMPLE_PERIOD = 1'b0;
   localparam logic REG_INVERT_MASK   = 1'b1;

   // per-request control from the sampler
   typedef struct packed {
      logic accept;
      logic take;
   } tick_type;

endpackage

### rtl/bmd_req_if.sv
// bmd_req_if: request channel carrying the raw pin levels of one tick
// depends on bmd_pkg
`timescale 1ns / 1ps

interface bmd_req_if
   import bmd_pkg::*;
   ;
   logic      valid;
   logic      ready;
   field_type raw_pins;

   modport source (output valid, output raw_pins, input ready);
   modport sink   (input valid, input raw_pins, output ready);
endinterface

### rtl/bmd_rsp_if.sv
// bmd_rsp_if: result channel carrying the debounced button vector
// depends on bmd_pkg
`timescale 1ns / 1ps

interface bmd_rsp_if
   import bmd_pkg::*;
   ;
   logic      valid;
   logic      ready;
   field_type debounced_buttons;
   logic      sample_taken;

   modport source (output valid, output debounced_buttons, output sample_taken, input ready);
   modport sink   (input valid, input debounced_buttons, input sample_taken, output ready);
endinterface

### rtl/bmd_sampler.sv
// bmd_sampler: configuration registers and the sample countdown
// depends on bmd_pkg
`timescale 1ns / 1ps

module bmd_sampler
   import bmd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  csr_data_type          csr_pwdata,
   output csr_data_type          csr_prdata,
   input  logic                  accept,
   output tick_type              tick,
   output field_type             invert_mask
);

   period_type period_ff, period_in;
   field_type  invert_ff, invert_in;
   period_type ticks_ff, ticks_in;
   logic       csr_write;
   logic       take;

   assign csr_write = csr_psel & csr_penable & csr_pwrite;
   assign take      = (ticks_ff <= period_type'(1));

   always_comb begin
      period_in = period_ff;
      invert_in = invert_ff;
      if (csr_write) begin
         unique case (csr_paddr[2])
            REG_SAMPLE_PERIOD: period_in = csr_pwdata[PERIOD_W-1:0];
            REG_INVERT_MASK:   invert_in = csr_pwdata[FIELD_W-1:0];
            default:           ;
         endcase
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (csr_paddr[2])
         REG_SAMPLE_PERIOD: csr_prdata = csr_data_type'(period_ff);
         REG_INVERT_MASK:   csr_prdata = csr_data_type'(invert_ff);
         default:           csr_prdata = '0;
      endcase
   end

   // a period of zero behaves as one
   always_comb begin
      ticks_in = ticks_ff;
      if (accept) begin
         if (take) begin
            ticks_in = (period_ff == '0) ? period_type'(1) : period_ff;
         end else begin
            ticks_in = ticks_ff - period_type'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
         invert_ff <= INVERT_RESET;
         ticks_ff  <= PERIOD_RESET;
      end else begin
         period_ff <= period_in;
         invert_ff <= invert_in;
         ticks_ff  <= ticks_in;
      end
   end

   assign tick.accept = accept;
   assign tick.take   = take;
   assign invert_mask = invert_ff;

endmodule

### rtl/bmd_lane.sv
// bmd_lane: sample window and majority vote of one button
// depends on bmd_pkg
`timescale 1ns / 1ps

module bmd_lane
   import bmd_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEFAULT
)(
   input  logic     clock,
   input  logic     reset,
   input  tick_type tick,
   input  logic     sample_bit,
   output logic     pressed
);

   localparam int CNT_W = $clog2(WINDOW + 1);

   logic [WINDOW-1:0] window_ff, window_in;
   logic [CNT_W-1:0]  ones;

   always_comb begin
      window_in = window_ff;
      if (tick.accept && tick.take) begin
         window_in = (window_ff << 1) | WINDOW'(sample_bit);
      end
   end

   // vote on the window as it stands after this request
   always_comb begin
      ones = '0;
      for (int k = 0; k < WINDOW; k++) begin
         ones = ones + CNT_W'(window_in[k]);
      end
   end

   assign pressed = ({ones, 1'b0} >= (CNT_W + 1)'(WINDOW));

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
      end else begin
         window_ff <= window_in;
      end
   end

endmodule

### rtl/bmd_merge.sv
// bmd_merge: gathers the lane votes into one vector and holds results in an output skid
// depends on bmd_pkg and bmd_rsp_if
`timescale 1ns / 1ps

module bmd_merge
   import bmd_pkg::*;
#(
   parameter int LANES = NUM_BUTTONS_DEFAULT
)(
   input  logic             clock,
   input  logic             reset,
   input  tick_type         tick,
   input  logic [LANES-1:0] lane_pressed,
   output logic             ready,
   bmd_rsp_if.source        rsp_if
);

   field_type vote;
   field_type out_vote_ff, out_vote_in, skid_vote_ff, skid_vote_in;
   logic      out_taken_ff, out_taken_in, skid_taken_ff, skid_taken_in;
   logic      out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic      pop;

   // buttons without a lane read as released
   always_comb begin
      vote = '0;
      for (int b = 0; b < LANES; b++) begin
         vote[b] = lane_pressed[b];
      end
   end

   assign pop = out_valid_ff & rsp_if.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_vote_in   = out_vote_ff;
      out_taken_in  = out_taken_ff;
      skid_valid_in = skid_valid_ff;
      skid_vote_in  = skid_vote_ff;
      skid_taken_in = skid_taken_ff;
      if (tick.accept) begin
         if (!out_valid_ff || pop) begin
            out_valid_in = 1'b1;
            out_vote_in  = vote;
            out_taken_in = tick.take;
         end else begin
            skid_valid_in = 1'b1;
            skid_vote_in  = vote;
            skid_taken_in = tick.take;
         end
      end else if (pop) begin
         if (skid_valid_ff) begin
            out_vote_in   = skid_vote_ff;
            out_taken_in  = skid_taken_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_vote_ff   <= out_vote_in;
      out_taken_ff  <= out_taken_in;
      skid_vote_ff  <= skid_vote_in;
      skid_taken_ff <= skid_taken_in;
   end

   assign ready                    = ~skid_valid_ff;
   assign rsp_if.valid             = out_valid_ff;
   assign rsp_if.debounced_buttons = out_vote_ff;
   assign rsp_if.sample_taken      = out_taken_ff;

endmodule

### rtl/button_majority_debounce_unit.sv
// button_majority_debounce_unit: top level of the majority vote button debounce filter
// depends on bmd_pkg, bmd_req_if, bmd_rsp_if, bmd_sampler, bmd_lane, bmd_merge
`timescale 1ns / 1ps
//
// Each request on req_if is one millisecond tick with the raw level of every button pin.
// A countdown paced by sample_period picks the ticks on which the pins, XORed with
// invert_mask, are shifted into a window of the last WINDOW samples; one lane per button
// holds its window and votes pressed when at least half the samples are ones.
// Every request gives exactly one response on rsp_if: the debounced vector and a flag
// that tells whether this tick took a sample.
// Requests are taken one per clock while req_if.ready is high. Each response is registered in the
// output register, or in the skid entry while an unread response still holds that register.
// A two-entry output skid sits before rsp_if; req_if.ready drops only while both entries
// hold unread responses, so a stalled receiver holds off requests after two ticks.
// Registers on csr_ (APB, pready always high): sample_period at 0x0, invert_mask at 0x4;
// write them only while no response is outstanding.
// Reset (synchronous, active high) clears the windows, loads sample_period with 10,
// invert_mask with 31 and the countdown with 10, and empties the output skid.
//

module button_majority_debounce_unit
   import bmd_pkg::*;
#(
   parameter int NUM_BUTTONS = NUM_BUTTONS_DEFAULT,
   parameter int WINDOW      = WINDOW_DEFAULT
)(
   input  logic                  clock,
   input  logic                  reset,
   bmd_req_if.sink               req_if,
   bmd_rsp_if.source             rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  csr_data_type          csr_pwdata,
   output csr_data_type          csr_prdata,
   output logic                  csr_pready
);

   // only the buttons present on the pins get a lane
   localparam int LANES = (NUM_BUTTONS < FIELD_W) ? NUM_BUTTONS : FIELD_W;

   logic             ready;
   logic             accept;
   tick_type         tick;
   field_type        invert_mask;
   field_type        sample_vec;
   logic [LANES-1:0] lane_pressed;

   assign accept      = req_if.valid & ready;
   assign req_if.ready = ready;
   assign csr_pready  = 1'b1;
   assign sample_vec  = req_if.raw_pins ^ invert_mask;

   bmd_sampler u_sampler (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .accept      (accept),
      .tick        (tick),
      .invert_mask (invert_mask)
   );

   for (genvar b = 0; b < LANES; b++) begin : g_lane
      bmd_lane #(
         .WINDOW (WINDOW)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .tick       (tick),
         .sample_bit (sample_vec[b]),
         .pressed    (lane_pressed[b])
      );
   end

   bmd_merge #(
      .LANES (LANES)
   ) u_merge (
      .clock        (clock),
      .reset        (reset),
      .tick         (tick),
      .lane_pressed (lane_pressed),
      .ready        (ready),
      .rsp_if       (rsp_if)
   );

endmodule

### tb/sv/button_majority_debounce_unit_tb.sv
// button_majority_debounce_unit_tb: self-checking bench for the majority vote debounce unit,
// drives tick requests and APB register writes and checks every response against a predictor
// depends on bmd_pkg, bmd_req_if, bmd_rsp_if and button_majority_debounce_unit
`timescale 1ns / 1ps

module button_majority_debounce_unit_tb;
   import bmd_pkg::*;

   localparam int NUM_BUTTONS = NUM_BUTTONS_DEFAULT;
   localparam int WINDOW      = WINDOW_DEFAULT;
   localparam int STUCK_LIMIT = 3000;
   localparam int HOLD_OFF    = 300;

   typedef struct packed {
      field_type buttons;
      logic      taken;
   } debounce_result_type;

   logic clock;
   logic reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   csr_data_type          csr_pwdata;
   csr_data_type          csr_prdata;
   logic                  csr_pready;

   bmd_req_if req_if();
   bmd_rsp_if rsp_if();

   button_majority_debounce_unit #(
      .NUM_BUTTONS(NUM_BUTTONS),
      .WINDOW(WINDOW)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_if(req_if),
      .rsp_if(rsp_if),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // predictor copy of the block state
   period_type model_period;
   field_type  model_invert;
   period_type model_countdown;
   field_type  model_window [WINDOW];

   debounce_result_type debounce_expect_q [$];

   int unsigned ticks_accepted;
   int unsigned samples_predicted;
   int unsigned csr_writes;
   int unsigned mismatches;
   int unsigned stuck_cycles;
   int unsigned sender_idle_pct;
   int unsigned receiver_idle_pct;
   int unsigned stall_request;
   int unsigned stall_left;

   always #1 clock = ~clock;

   function automatic debounce_result_type predict_debounce(input field_type pins);
      debounce_result_type r;
      int ones;
      r.taken = 1'b0;
      if (model_countdown <= 1) begin
         for (int k = 0; k < WINDOW - 1; k++) model_window[k] = model_window[k + 1];
         model_window[WINDOW - 1] = pins ^ model_invert;
         model_countdown = (model_period == 0) ? period_type'(1) : model_period;
         r.taken = 1'b1;
      end else begin
         model_countdown = model_countdown - 1'b1;
      end
      r.buttons = '0;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
         ones = 0;
         for (int k = 0; k < WINDOW; k++) ones += model_window[k][b];
         if (2 * ones >= WINDOW) r.buttons[b] = 1'b1;
      end
      return r;
   endfunction

   function automatic void note_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
   endfunction

   // response check first, then prediction of the request taken at the same edge
   always @(posedge clock) begin
      debounce_result_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (debounce_expect_q.size() == 0) begin
               note_mismatch("response with no request outstanding");
            end else begin
               want = debounce_expect_q.pop_front();
               if (rsp_if.debounced_buttons !== want.buttons)
                  note_mismatch($sformatf("debounced_buttons expected %02h got %02h",
                                          want.buttons, rsp_if.debounced_buttons));
               if (rsp_if.sample_taken !== want.taken)
                  note_mismatch($sformatf("sample_taken expected %0b got %0b",
                                          want.taken, rsp_if.sample_taken));
            end
         end
         if (req_if.valid && req_if.ready) begin
            want = predict_debounce(req_if.raw_pins);
            if (want.taken) samples_predicted++;
            debounce_expect_q.push_back(want);
            ticks_accepted++;
         end
      end
   end

   // receiver: random ready, or a long hold-off when one is requested
   always @(negedge clock) begin
      if (stall_request != 0) begin
         stall_left = stall_request;
         stall_request = 0;
      end
      if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_if.ready = 1'b0;
      end else begin
         rsp_if.ready = ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_psel && csr_penable)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("no progress for %0d cycles", STUCK_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   task automatic send_tick(input field_type pins);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_if.valid = 1'b0;
         req_if.raw_pins = field_type'($urandom);
         @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.raw_pins = pins;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (debounce_expect_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(input logic reg_sel, input csr_data_type data);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b1;
      csr_paddr = {reg_sel, 2'b00};
      csr_pwdata = data;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      if (reg_sel == REG_SAMPLE_PERIOD) model_period = data[PERIOD_W-1:0];
      else model_invert = data[FIELD_W-1:0];
      csr_writes++;
   endtask

   task automatic check_register(input logic reg_sel);
      csr_data_type want;
      csr_data_type got;
      want = (reg_sel == REG_SAMPLE_PERIOD) ? csr_data_type'(model_period)
                                           : csr_data_type'(model_invert);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = {reg_sel, 2'b00};
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      got = csr_prdata;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      if (got !== want)
         note_mismatch($sformatf("register %0d read expected %08h got %08h",
                                 reg_sel, want, got));
   endtask

   // a button pattern held for a few sample periods with some bounce on it, or random pins on every tick
   task automatic send_episode(input int unsigned span);
      field_type level;
      int unsigned len;
      bit noisy;
      level = field_type'($urandom);
      len = span * $urandom_range(1, 7) + $urandom_range(0, span);
      if (len > 40) len = 40;
      if (len == 0) len = 1;
      noisy = ($urandom_range(9) == 0);
      for (int i = 0; i < len; i++) begin
         if (noisy) send_tick(field_type'($urandom));
         else if ($urandom_range(99) < 15) send_tick(level ^ field_type'($urandom_range(1, 31)));
         else send_tick(level);
      end
   endtask

   task automatic test_register_access();
      csr_write(REG_SAMPLE_PERIOD, {16'($urandom), 16'd1});
      check_register(REG_SAMPLE_PERIOD);
      csr_write(REG_SAMPLE_PERIOD, {16'($urandom), 16'hFFFF});
      check_register(REG_SAMPLE_PERIOD);
      csr_write(REG_SAMPLE_PERIOD, {16'($urandom), 16'($urandom)});
      check_register(REG_SAMPLE_PERIOD);
      csr_write(REG_INVERT_MASK, {27'($urandom), 5'd0});
      check_register(REG_INVERT_MASK);
      csr_write(REG_INVERT_MASK, {27'($urandom), 5'd31});
      check_register(REG_INVERT_MASK);
   endtask

   // reset countdown of ten, then period zero sampling every tick, then invert changes
   task automatic test_directed_ticks();
      field_type walk [10] = '{5'd0, 5'd31, 5'd1, 5'd2, 5'd4, 5'd8, 5'd16, 5'd21, 5'd10, 5'd31};
      csr_write(REG_SAMPLE_PERIOD, 32'd0);
      csr_write(REG_INVERT_MASK, 32'd0);
      foreach (walk[i]) send_tick(walk[i]);
      repeat (5) send_tick(5'd31);
      repeat (3) send_tick(5'd0);
      wait_for_results();
      csr_write(REG_INVERT_MASK, 32'd31);
      repeat (2) send_tick(5'd31);
      wait_for_results();
   endtask

   task automatic test_random_phase(input int unsigned send_pct, input int unsigned recv_pct,
                                    input int unsigned n_ticks);
      int unsigned target;
      int unsigned setting_end;
      int unsigned pick;
      period_type per;
      int unsigned span;
      sender_idle_pct = send_pct;
      receiver_idle_pct = recv_pct;
      target = ticks_accepted + n_ticks;
      while (ticks_accepted < target) begin
         wait_for_results();
         pick = $urandom_range(99);
         if (pick < 70) per = period_type'($urandom_range(1, 4));
         else if (pick < 90) per = period_type'($urandom_range(5, 16));
         else if (pick < 95) per = '0;
         else per = period_type'($urandom_range(17, 40));
         if ($urandom_range(3) != 0) csr_write(REG_SAMPLE_PERIOD, {16'($urandom), per});
         csr_write(REG_INVERT_MASK, {27'($urandom), 5'($urandom)});
         span = (model_period == 0) ? 1 : model_period;
         setting_end = ticks_accepted + $urandom_range(50, 90);
         while (ticks_accepted < setting_end && ticks_accepted < target) send_episode(span);
      end
      wait_for_results();
   endtask

   // receiver stalls long while the sender keeps offering, then the sender waits for all
   task automatic test_backpressure();
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      csr_write(REG_SAMPLE_PERIOD, 32'd2);
      @(posedge clock);
      stall_request = HOLD_OFF;
      for (int i = 0; i < 40; i++) send_tick(field_type'($urandom));
      wait_for_results();
      for (int i = 0; i < 20; i++) send_tick(field_type'($urandom));
      wait_for_results();
   endtask

   task automatic test_longest_period();
      sender_idle_pct = 10;
      receiver_idle_pct = 10;
      csr_write(REG_SAMPLE_PERIOD, 32'hFFFF);
      csr_write(REG_INVERT_MASK, 32'($urandom));
      check_register(REG_SAMPLE_PERIOD);
      check_register(REG_INVERT_MASK);
      for (int i = 0; i < 60; i++) send_tick(field_type'($urandom));
      wait_for_results();
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.raw_pins = '0;
      rsp_if.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      model_period = PERIOD_RESET;
      model_invert = INVERT_RESET;
      model_countdown = PERIOD_RESET;
      foreach (model_window[k]) model_window[k] = '0;
      ticks_accepted = 0;
      samples_predicted = 0;
      csr_writes = 0;
      mismatches = 0;
      stuck_cycles = 0;
      stall_request = 0;
      stall_left = 0;
      sender_idle_pct = 28;
      receiver_idle_pct = 82;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      check_register(REG_SAMPLE_PERIOD);
      check_register(REG_INVERT_MASK);
      test_register_access();
      test_directed_ticks();
      test_random_phase(28, 82, 560);
      test_backpressure();
      test_random_phase(82, 28, 560);
      test_random_phase(0, 0, 560);
      test_longest_period();

      wait_for_results();
      if (debounce_expect_q.size() != 0)
         note_mismatch($sformatf("%0d responses never arrived", debounce_expect_q.size()));
      $display("run covered %0d ticks with %0d samples taken and %0d register writes,",
               ticks_accepted, samples_predicted, csr_writes);
      $display("sample periods from zero to 65535 under three idle mixes; %0d mismatches",
               mismatches);
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
